// ===== sv/upc_pkg.sv =====
// Package for the URL percent codec: command type passed from front to back,
// queue sizing and the character helper functions. No dependencies.
`default_nettype none

package upc_pkg;

  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QLevelW = $clog2(QDepth + 1);

  localparam logic [7:0] CharPct = 8'h25;

  // unescape progress: nothing, a '%' held, '%' plus first hex char held
  typedef enum logic [1:0] {
    HELD_NONE    = 2'd0,
    HELD_PCT     = 2'd1,
    HELD_PCT_CHR = 2'd2
  } held_e;

  // one accepted byte worth of output: cnt bytes, last flag on the final one
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] idx;
    logic [1:0] cnt;
  } back_stat_t;

  function automatic logic is_plain(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
    return t[3:0];
  endfunction

  function automatic logic [7:0] hex_chr(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

endpackage

`default_nettype wire

// ===== sv/upc_front.sv =====
// Front end: accepts input bytes, tracks the unescape hold state and turns
// each byte into a command of zero to three output bytes. Uses upc_pkg.
`default_nettype none

module upc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mode_i,
  input  wire logic          clear_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_byte_i,
  output upc_pkg::cmd_t      cmd_o,
  output logic               push_o
);

  upc_pkg::held_e held_q, held_d;
  logic [7:0]     chr_q, chr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= upc_pkg::HELD_NONE;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
  end

  always_comb begin
    held_d      = held_q;
    chr_d       = chr_q;
    push_o      = 1'b0;
    cmd_o.cnt   = 2'd0;
    cmd_o.b0    = data_byte_i;
    cmd_o.b1    = 8'h00;
    cmd_o.b2    = 8'h00;
    cmd_o.last  = last_byte_i;
    if (accept_i) begin
      if (!mode_i) begin
        push_o = 1'b1;
        if (upc_pkg::is_plain(data_byte_i)) begin
          cmd_o.cnt = 2'd1;
        end else begin
          cmd_o.cnt = 2'd3;
          cmd_o.b0  = upc_pkg::CharPct;
          cmd_o.b1  = upc_pkg::hex_chr(data_byte_i[7:4]);
          cmd_o.b2  = upc_pkg::hex_chr(data_byte_i[3:0]);
        end
      end else begin
        unique case (held_q)
          upc_pkg::HELD_PCT_CHR: begin
            push_o    = 1'b1;
            held_d    = upc_pkg::HELD_NONE;
            cmd_o.cnt = 2'd1;
            cmd_o.b0  = {upc_pkg::hex_val(chr_q), upc_pkg::hex_val(data_byte_i)};
          end
          upc_pkg::HELD_PCT: begin
            if (last_byte_i) begin
              // stream ends early: held '%' leaves as a literal
              push_o    = 1'b1;
              held_d    = upc_pkg::HELD_NONE;
              cmd_o.cnt = 2'd2;
              cmd_o.b0  = upc_pkg::CharPct;
              cmd_o.b1  = data_byte_i;
            end else begin
              chr_d  = data_byte_i;
              held_d = upc_pkg::HELD_PCT_CHR;
            end
          end
          default: begin
            held_d = upc_pkg::HELD_NONE;
            if (data_byte_i == upc_pkg::CharPct && !last_byte_i) begin
              held_d = upc_pkg::HELD_PCT;
            end else begin
              push_o    = 1'b1;
              cmd_o.cnt = 2'd1;
            end
          end
        endcase
      end
    end
    if (clear_i) held_d = upc_pkg::HELD_NONE;
  end

endmodule

`default_nettype wire

// ===== sv/upc_queue.sv =====
// Short command queue between front and back end.
// Uses upc_pkg for the command type and depth.
`default_nettype none

module upc_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire upc_pkg::cmd_t             cmd_i,
  input  wire logic                      pop_i,
  output upc_pkg::cmd_t                  cmd_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [upc_pkg::QLevelW-1:0]    level_o
);

  upc_pkg::cmd_t                   mem_q [upc_pkg::QDepth];
  logic [upc_pkg::QPtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [upc_pkg::QLevelW-1:0]     lvl_q, lvl_d;

  function automatic logic [upc_pkg::QPtrW-1:0] ptr_inc(
      input logic [upc_pkg::QPtrW-1:0] p);
    return (p == upc_pkg::QPtrW'(upc_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (lvl_q == upc_pkg::QLevelW'(upc_pkg::QDepth));
  assign empty_o = (lvl_q == '0);
  assign level_o = lvl_q;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i  ? ptr_inc(rd_q) : rd_q;
    lvl_d = lvl_q;
    if (push_i && !pop_i) lvl_d = lvl_q + 1'b1;
    else if (!push_i && pop_i) lvl_d = lvl_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

// ===== sv/upc_back.sv =====
// Back end: takes commands from the queue and sends their bytes one per
// cycle on the output channel while out_stall_i is low. Uses upc_pkg.
`default_nettype none

module upc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire upc_pkg::cmd_t cmd_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output upc_pkg::back_stat_t stat_o
);

  upc_pkg::cmd_t cur_q, cur_d;
  logic          busy_q, busy_d;
  logic [1:0]    idx_q, idx_d;
  logic          xfer, at_end;

  assign xfer        = busy_q && !out_stall_i;
  assign at_end      = (idx_q == cur_q.cnt - 2'd1);
  assign out_valid_o = busy_q;
  assign out_last_o  = cur_q.last && at_end;
  assign stat_o      = '{busy: busy_q, idx: idx_q, cnt: cur_q.cnt};

  always_comb begin
    unique case (idx_q)
      2'd0:    out_byte_o = cur_q.b0;
      2'd1:    out_byte_o = cur_q.b1;
      default: out_byte_o = cur_q.b2;
    endcase
  end

  always_comb begin
    cur_d  = cur_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    pop_o  = 1'b0;
    if (!busy_q || (xfer && at_end)) begin
      pop_o  = !empty_i;
      busy_d = !empty_i;
      idx_d  = 2'd0;
      if (!empty_i) cur_d = cmd_i;
    end else if (xfer) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

`default_nettype wire

// ===== sv/url_percent_codec_unit.sv =====
// Top level of the URL percent codec: APB register, front end, queue, back end.
// Depends on upc_pkg, upc_front, upc_queue and upc_back.
//
// Converts a byte stream marked by last_byte_i. decode_mode (address 0, bit 0)
// selects escape (0) or unescape (1); a write clears any held '%' sequence.
// An input byte is taken every cycle while the two-entry command queue has
// room; the output side moves one byte per cycle while out_stall_i is low,
// so in escape mode a byte that expands to three characters holds the
// output for all three of them, and the output channel sets the sustained
// input rate. A held '%' and its first hex character produce no output until
// the sequence completes.
`default_nettype none

module url_percent_codec_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  logic                          mode_q, mode_d;
  logic                          cfg_wr;
  logic                          accept;
  logic                          push, pop, full, empty;
  logic [upc_pkg::QLevelW-1:0]   level;
  upc_pkg::cmd_t                 f_cmd, q_cmd;
  upc_pkg::back_stat_t           bstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && !paddr[2];
  assign prdata  = paddr[2] ? 32'h0 : {31'h0, mode_q};
  assign mode_d  = cfg_wr ? pwdata[0] : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  upc_front u_front (
    .clk_i,
    .rst_ni,
    .mode_i      (mode_q),
    .clear_i     (cfg_wr),
    .accept_i    (accept),
    .data_byte_i,
    .last_byte_i,
    .cmd_o       (f_cmd),
    .push_o      (push)
  );

  upc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (f_cmd),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .full_o  (full),
    .empty_o (empty),
    .level_o (level)
  );

  upc_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_i       (q_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .out_last_o,
    .stat_o      (bstat)
  );

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= upc_pkg::QLevelW'(upc_pkg::QDepth))
    else $error("command queue level out of range");

  a_idx_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bstat.cnt != 2'd0 && bstat.idx < bstat.cnt))
    else $error("output index outside current command");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (bstat.idx == bstat.cnt - 2'd1))
    else $error("last flag before final byte of command");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (level != '0))
    else $error("pop from empty command queue");

endmodule

`default_nettype wire
